>>> sv/drt_pkg.sv
package drt_pkg;

    // fixed field widths
    localparam int DestW  = 6;
    localparam int PortW  = 4;
    localparam int CostW  = 20;
    localparam int SumW   = CostW + 1;
    // stored cost covers the widest infinity value
    localparam int StoreW = 24;
    localparam int CntW   = 11;

    localparam int DEST_COUNT_DEF    = 64;
    localparam int PORT_COUNT_DEF    = 16;
    localparam int COST_INFINITY_DEF = 999999;

    // destinations reachable through the dest field
    localparam int WalkMax = 64;

    localparam logic KIND_ROUTE = 1'b0;
    localparam logic KIND_ADV   = 1'b1;

    typedef struct packed {
        logic [PortW-1:0]  port;
        logic [StoreW-1:0] cost;
    } t_entry;

    typedef struct packed {
        logic re;
        logic we;
    } t_tbl_ctl;

endpackage

>>> sv/drt_if.sv
interface drt_in_if import drt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [PortW-1:0] port;
    logic [DestW-1:0] dest;
    logic [CostW-1:0] neighbor_cost;
    logic [CostW-1:0] link_cost;
    logic             last_in_update;

    modport source (
        output valid, kind, port, dest, neighbor_cost, link_cost, last_in_update,
        input  ready
    );
    modport sink (
        input  valid, kind, port, dest, neighbor_cost, link_cost, last_in_update,
        output ready
    );
endinterface

interface drt_out_if import drt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DestW-1:0] out_dest;
    logic [CostW-1:0] out_cost;
    logic             entry_valid;
    logic             route_installed;
    logic             update_changed;
    logic             last;

    modport source (
        output valid, out_dest, out_cost, entry_valid, route_installed, update_changed,
               last,
        input  ready
    );
    modport sink (
        input  valid, out_dest, out_cost, entry_valid, route_installed, update_changed,
               last,
        output ready
    );
endinterface

>>> sv/drt_table.sv
module drt_table import drt_pkg::*; #(
    parameter int DEPTH = DEST_COUNT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_tbl_ctl      i_ctl,
    input  logic [AW-1:0] i_raddr,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    output t_entry        o_rdata,
    output logic          o_rvalid
);

    t_entry             r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    t_entry             r_rdata;
    logic               r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata  <= r_mem[i_raddr];
            r_rvalid <= r_valid[i_raddr];
        end
    end

    // valid marks in flops so reset empties the table at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata  = r_rdata;
    assign o_rvalid = r_rvalid;

endmodule

>>> sv/distance_vector_route_table.sv
// channel    | direction | transaction
// i_route    | in        | route entry (kind 0) or advertise request (kind 1)
// o_result   | out       | route result, or one advertised table entry
// i_cfg_we   | in        | write of own_id from i_cfg_data
//
// a route entry goes through a table read, then compare and write-back.
// an advertise request reads each of min(DEST_COUNT, 64) destinations,
// one table read per cycle while the output does not stall; the last result
// leaves from a one-entry hold so that it can carry the last mark.
// reset is synchronous; it empties the table and clears own_id to 0.
// a stalled output holds the walk and blocks new transactions.
module distance_vector_route_table import drt_pkg::*; #(
    parameter int DEST_COUNT    = DEST_COUNT_DEF,
    parameter int PORT_COUNT    = PORT_COUNT_DEF,
    parameter int COST_INFINITY = COST_INFINITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DestW-1:0] i_cfg_data,
    drt_in_if.sink           i_route,
    drt_out_if.source        o_result
);

    localparam int Depth = (DEST_COUNT < WalkMax) ? DEST_COUNT : WalkMax;
    localparam int AW    = $clog2(Depth);
    localparam logic [AW-1:0]     IdxLast = AW'(Depth - 1);
    localparam logic [StoreW-1:0] CostInf = StoreW'(COST_INFINITY);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ROUTE = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [DestW-1:0]  r_own;
    logic              r_changed, n_changed;
    logic [PortW-1:0]  r_port, n_port;
    logic [DestW-1:0]  r_dest, n_dest;
    logic [StoreW-1:0] r_sum, n_sum;
    logic              r_ok, n_ok;
    logic              r_indom, n_indom;
    logic              r_lastu, n_lastu;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_hold_vld, n_hold_vld;
    logic [DestW-1:0]  r_hold_dest, n_hold_dest;
    logic [CostW-1:0]  r_hold_cost, n_hold_cost;
    logic              r_out_vld, n_out_vld;
    logic [DestW-1:0]  r_out_dest, n_out_dest;
    logic [CostW-1:0]  r_out_cost, n_out_cost;
    logic              r_out_ev, n_out_ev;
    logic              r_out_inst, n_out_inst;
    logic              r_out_chg, n_out_chg;
    logic              r_out_last, n_out_last;

    t_tbl_ctl          tbl_ctl;
    logic [AW-1:0]     tbl_raddr;
    t_entry            tbl_rdata;
    logic              tbl_rvalid;

    logic              accept;
    logic              out_free;
    logic              route_fire;
    logic              install;
    logic              own_match;
    logic              cand;
    logic              adv;
    logic [SumW-1:0]   raw_sum;
    logic [StoreW-1:0] sum_ext;
    logic              chg_all;

    drt_table #(
        .DEPTH (Depth),
        .AW    (AW)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (tbl_ctl),
        .i_raddr  (tbl_raddr),
        .i_waddr  (r_dest[AW-1:0]),
        .i_wdata  ({r_port, r_sum}),
        .o_rdata  (tbl_rdata),
        .o_rvalid (tbl_rvalid)
    );

    assign i_route.ready = (r_state == S_IDLE);
    assign accept        = i_route.valid && i_route.ready;
    assign out_free      = !r_out_vld || o_result.ready;

    assign raw_sum = SumW'(i_route.neighbor_cost) + SumW'(i_route.link_cost);
    assign sum_ext = StoreW'(raw_sum);

    // route compare against the word read in the accept cycle
    assign install    = r_ok && (!tbl_rvalid || (r_sum < tbl_rdata.cost));
    assign route_fire = (r_state == S_ROUTE) && out_free;
    assign chg_all    = r_changed || install;

    // walk: own entry always goes out, others by split horizon
    assign own_match = (DestW'(r_idx) == r_own);
    assign cand      = own_match || (tbl_rvalid && (tbl_rdata.port != r_port));
    assign adv       = (r_state == S_WALK) && (!cand || !r_hold_vld || out_free);

    always_comb begin
        tbl_ctl.we = route_fire && install;
        tbl_ctl.re = accept || (adv && (r_idx != IdxLast));
        if (accept) begin
            tbl_raddr = (i_route.kind == KIND_ROUTE) ? i_route.dest[AW-1:0] : '0;
        end else begin
            tbl_raddr = r_idx + AW'(1);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_changed   = r_changed;
        n_port      = r_port;
        n_dest      = r_dest;
        n_sum       = r_sum;
        n_ok        = r_ok;
        n_indom     = r_indom;
        n_lastu     = r_lastu;
        n_idx       = r_idx;
        n_hold_vld  = r_hold_vld;
        n_hold_dest = r_hold_dest;
        n_hold_cost = r_hold_cost;
        n_out_vld   = r_out_vld && !o_result.ready;
        n_out_dest  = r_out_dest;
        n_out_cost  = r_out_cost;
        n_out_ev    = r_out_ev;
        n_out_inst  = r_out_inst;
        n_out_chg   = r_out_chg;
        n_out_last  = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_port  = i_route.port;
                    n_dest  = i_route.dest;
                    n_lastu = i_route.last_in_update;
                    n_sum   = (sum_ext > CostInf) ? CostInf : sum_ext;
                    n_indom = (CntW'(i_route.dest) < CntW'(DEST_COUNT))
                              && (i_route.dest != r_own);
                    n_ok    = n_indom
                              && (StoreW'(i_route.neighbor_cost) < CostInf)
                              && (CntW'(i_route.port) < CntW'(PORT_COUNT));
                    n_idx   = '0;
                    n_state = (i_route.kind == KIND_ROUTE) ? S_ROUTE : S_WALK;
                end
            end
            S_ROUTE: begin
                if (route_fire) begin
                    n_out_vld  = 1'b1;
                    n_out_dest = r_dest;
                    if (!r_indom) begin
                        n_out_cost = '0;
                    end else if (install) begin
                        n_out_cost = r_sum[CostW-1:0];
                    end else if (tbl_rvalid) begin
                        n_out_cost = tbl_rdata.cost[CostW-1:0];
                    end else begin
                        n_out_cost = '0;
                    end
                    n_out_ev   = 1'b0;
                    n_out_inst = install;
                    n_out_chg  = r_lastu && chg_all;
                    n_out_last = 1'b1;
                    n_changed  = r_lastu ? 1'b0 : chg_all;
                    n_state    = S_IDLE;
                end
            end
            S_WALK: begin
                if (adv) begin
                    if (cand) begin
                        if (r_hold_vld) begin
                            n_out_vld  = 1'b1;
                            n_out_dest = r_hold_dest;
                            n_out_cost = r_hold_cost;
                            n_out_ev   = 1'b1;
                            n_out_inst = 1'b0;
                            n_out_chg  = 1'b0;
                            n_out_last = 1'b0;
                        end
                        n_hold_vld  = 1'b1;
                        n_hold_dest = DestW'(r_idx);
                        n_hold_cost = own_match ? '0 : tbl_rdata.cost[CostW-1:0];
                    end
                    if (r_idx == IdxLast) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            S_FIN: begin
                if (!r_hold_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_dest = r_hold_dest;
                    n_out_cost = r_hold_cost;
                    n_out_ev   = 1'b1;
                    n_out_inst = 1'b0;
                    n_out_chg  = 1'b0;
                    n_out_last = 1'b1;
                    n_hold_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_own      <= '0;
            r_changed  <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_changed  <= n_changed;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we) begin
                r_own <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_port      <= n_port;
        r_dest      <= n_dest;
        r_sum       <= n_sum;
        r_ok        <= n_ok;
        r_indom     <= n_indom;
        r_lastu     <= n_lastu;
        r_idx       <= n_idx;
        r_hold_dest <= n_hold_dest;
        r_hold_cost <= n_hold_cost;
        r_out_dest  <= n_out_dest;
        r_out_cost  <= n_out_cost;
        r_out_ev    <= n_out_ev;
        r_out_inst  <= n_out_inst;
        r_out_chg   <= n_out_chg;
        r_out_last  <= n_out_last;
    end

    assign o_result.valid           = r_out_vld;
    assign o_result.out_dest        = r_out_dest;
    assign o_result.out_cost        = r_out_cost;
    assign o_result.entry_valid     = r_out_ev;
    assign o_result.route_installed = r_out_inst;
    assign o_result.update_changed  = r_out_chg;
    assign o_result.last            = r_out_last;

    // own entry is always held before the walk finishes when it lies in range
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && CntW'(r_own) < CntW'(Depth)) |-> r_hold_vld)
        else $error("walk finished without a held entry");

    a_chg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (route_fire && r_lastu) |=> !r_changed)
        else $error("update change flag not cleared at end of update");

    a_out_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !(o_result.entry_valid
                             && (o_result.route_installed || o_result.update_changed)))
        else $error("advertised entry carries route flags");

    a_tbl_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_ctl.we |-> !tbl_ctl.re)
        else $error("table read and write in the same cycle");

endmodule
